// ===== hdl/ece_pkg.sv =====
// ----------------------------------------------------------------------------
// ece_pkg
// shared types and constants for the easing curve evaluator
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int TIME_BITS_DEF        = 24;
  localparam int FRAC_BITS_DEF        = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int MODE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [MODE_BITS-1:0]      mode_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_DURATION   = 2'd0;
  localparam cfg_index_t CFG_CURVE_MODE = 2'd1;

  localparam mode_t MODE_LINEAR    = 3'd0;
  localparam mode_t MODE_SQUARE_IN = 3'd1;
  localparam mode_t MODE_SQUARE_OUT= 3'd2;
  localparam mode_t MODE_CUBE_IN   = 3'd3;
  localparam mode_t MODE_CUBE_OUT  = 3'd4;
  localparam mode_t MODE_SINE      = 3'd5;
  localparam mode_t MODE_COSINE    = 3'd6;

  // control word moving along the divider row
  typedef struct packed {
    logic valid;
    logic lo;   // ratio clamps to zero
    logic hi;   // ratio clamps to one
  } ece_ctl_t;

endpackage

// ===== hdl/ece_div_cell.sv =====
// ----------------------------------------------------------------------------
// ece_div_cell
// one restoring division step: doubles the remainder and yields one
// quotient bit, registered toward the next cell
// ----------------------------------------------------------------------------
module ece_div_cell #(
  parameter int RW = 23,
  parameter int QW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ece_pkg::ece_ctl_t ctl_in,
  input  logic [RW-1:0]     rem_in,
  input  logic [QW-1:0]     quot_in,
  input  logic [RW-1:0]     divisor,
  output ece_pkg::ece_ctl_t ctl_out,
  output logic [RW-1:0]     rem_out,
  output logic [QW-1:0]     quot_out
);
  import ece_pkg::*;

  logic [RW:0]   r2;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_next;

  assign r2       = {rem_in, 1'b0};
  assign ge       = r2 >= {1'b0, divisor};
  assign diff     = r2 - {1'b0, divisor};
  assign rem_next = ge ? diff[RW-1:0] : r2[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rem_out  <= rem_next;
    quot_out <= {quot_in[QW-2:0], ge};
  end

endmodule

// ===== hdl/ece_curve.sv =====
// ----------------------------------------------------------------------------
// ece_curve
// four-stage curve unit: powers, quarter-wave sine lookup and the mode select
// ----------------------------------------------------------------------------
module ece_curve #(
  parameter int FRAC_BITS        = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [FRAC_BITS:0]   x,
  input  ece_pkg::mode_t       mode,
  input  logic                 dur_zero,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   level
);
  import ece_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int D  = SINE_TABLE_DEPTH;
  localparam int KW = $clog2(D + 1);
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  typedef logic [F:0] rom_t [0:D];

  // shift-subtract quotient, only used while building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned sin_q30(input longint unsigned theta);
    longint unsigned t2;
    longint unsigned term;
    longint unsigned den;
    longint          sum;
    t2   = (theta * theta) >> 30;
    term = theta;
    sum  = longint'(theta);
    for (int k = 1; k <= 6; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = udiv((term * t2) >> 30, den);
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return $unsigned(sum);
  endfunction

  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned theta;
    longint unsigned v;
    for (int i = 0; i <= D; i++) begin
      theta = (longint'(1686629713) * longint'(i)) / D;
      v = (sin_q30(theta) + (longint'(1) << (29 - F))) >> (30 - F);
      if (v > (longint'(1) << F)) v = longint'(1) << F;
      r[i] = v[F:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // stage a: square and table read
  logic [F:0]      b;
  logic [2*F+1:0]  bb;
  logic [F+KW-1:0] p;
  logic [KW-1:0]   k;
  logic            k_top;
  logic [KW-1:0]   k1;

  assign b     = (mode == MODE_SQUARE_OUT || mode == MODE_CUBE_OUT) ? ONE - x : x;
  assign bb    = b * b;
  assign p     = x * KW'(D);
  assign k     = p[F+KW-1:F];
  assign k_top = k >= KW'(D);
  assign k1    = k + KW'(1);

  logic           a_valid;
  logic [F:0]     a_x, a_b, a_sq, a_rk, a_rk1;
  logic [F-1:0]   a_f;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= in_valid;
    a_x   <= x;
    a_b   <= b;
    a_sq  <= bb[2*F:F];
    a_rk  <= k_top ? SINE_ROM[D] : SINE_ROM[k];
    a_rk1 <= k_top ? SINE_ROM[D] : SINE_ROM[k1];
    a_f   <= k_top ? '0 : p[F-1:0];
  end

  // stage b: cube and interpolation
  logic [2*F+1:0] cb;
  logic [F:0]     dr;
  logic [2*F:0]   dp;
  logic [F:0]     s_next;

  assign cb     = a_sq * a_b;
  assign dr     = a_rk1 - a_rk;
  assign dp     = dr * a_f;
  assign s_next = a_rk + dp[2*F:F];

  logic       b_valid;
  logic [F:0] b_x, b_sq, b_cube, b_s;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= a_valid;
    b_x    <= a_x;
    b_sq   <= a_sq;
    b_cube <= cb[2*F:F];
    b_s    <= s_next;
  end

  // stage c: sine squared gives the half cosine
  logic [2*F+1:0] ss;
  assign ss = b_s * b_s;

  logic       c_valid;
  logic [F:0] c_x, c_sq, c_cube, c_s, c_s2;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else     c_valid <= b_valid;
    c_x    <= b_x;
    c_sq   <= b_sq;
    c_cube <= b_cube;
    c_s    <= b_s;
    c_s2   <= ss[2*F:F];
  end

  // output stage
  logic [F:0] sel;
  logic [F:0] level_next;

  always_comb begin
    case (mode)
      MODE_SQUARE_IN:  sel = c_sq;
      MODE_SQUARE_OUT: sel = ONE - c_sq;
      MODE_CUBE_IN:    sel = c_cube;
      MODE_CUBE_OUT:   sel = ONE - c_cube;
      MODE_SINE:       sel = c_s;
      MODE_COSINE:     sel = c_s2;
      default:         sel = c_x;
    endcase
    if (dur_zero)       level_next = '0;
    else if (sel > ONE) level_next = ONE;
    else                level_next = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= c_valid;
    level <= level_next;
  end

endmodule

// ===== hdl/easing_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// eased progress level from an elapsed time, duration and curve mode
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a signed elapsed time; the word is taken on any edge
//   with start high and busy low. busy stays low, so one word can enter
//   every cycle.
//   Each word gives exactly one level, shown for one cycle with done high.
//   The receiver cannot stall; results leave in input order, one per cycle.
//   A word passes the input stage and then the divider row: one cell
//   per quotient bit, FRAC_BITS cells, then four curve stages (square,
//   cube/interpolate, sine squared, select).
//   Configuration goes through cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 for duration and 1 for curve_mode; other indexes are
//   ignored. Write only while no words are in flight.
//   Synchronous reset clears the pipeline valids and sets both registers
//   to zero; a zero duration gives level 0.
// ----------------------------------------------------------------------------
module easing_curve_evaluator #(
  parameter int TIME_BITS        = ece_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS        = ece_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ece_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [TIME_BITS-1:0] elapsed,
  output logic                        done,
  output logic [FRAC_BITS:0]          level,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  ece_pkg::cfg_index_t         cfg_index,
  input  logic [TIME_BITS-2:0]        cfg_data
);
  import ece_pkg::*;

  localparam int RW  = TIME_BITS - 1;
  localparam int F   = FRAC_BITS;
  localparam int LAT = F + 5;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [RW-1:0] duration;
  mode_t         curve_mode;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= '0;
      curve_mode <= MODE_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DURATION:   duration   <= cfg_data;
        CFG_CURVE_MODE: curve_mode <= cfg_data[MODE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // input stage: clamp flags and starting remainder
  ece_ctl_t ctl [0:F];
  logic [RW-1:0] rem [0:F];
  logic [F-1:0]  quot [0:F];

  logic lo_next;
  assign lo_next = elapsed[TIME_BITS-1] || (elapsed == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].valid <= start && !busy;
      ctl[0].lo    <= lo_next;
      ctl[0].hi    <= !lo_next && (elapsed[RW-1:0] >= duration);
    end
    rem[0]  <= elapsed[RW-1:0];
    quot[0] <= '0;
  end

  for (genvar i = 0; i < F; i++) begin : g_div
    ece_div_cell #(.RW(RW), .QW(F)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl[i]),
      .rem_in   (rem[i]),
      .quot_in  (quot[i]),
      .divisor  (duration),
      .ctl_out  (ctl[i+1]),
      .rem_out  (rem[i+1]),
      .quot_out (quot[i+1])
    );
  end

  logic [F:0] x;
  assign x = ctl[F].lo ? '0 : (ctl[F].hi ? ONE : {1'b0, quot[F]});

  ece_curve #(.FRAC_BITS(F), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_curve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctl[F].valid),
    .x         (x),
    .mode      (curve_mode),
    .dur_zero  (duration == '0),
    .out_valid (done),
    .level     (level)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching input word");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("input word produced no result");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    done |-> level <= ONE)
    else $error("level above one");

  a_zero_duration: assert property (@(posedge clk) disable iff (rst)
    (done && duration == '0 && $past(duration == '0, LAT)) |-> level == '0)
    else $error("nonzero level with zero duration");

endmodule
